@@ rtl/assert_macros.svh @@
// Assertion helpers used by brbs_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, off while reset is asserted.
`define BRBS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("brbs assertion failed");

// Clocked property, checked during reset as well.
`define BRBS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("brbs assertion failed");

`endif

@@ rtl/brbs_pkg.sv @@
`timescale 1ns / 1ps
package brbs_pkg;

    localparam int MAX_BLOCK_BYTES = 4096;
    localparam int MAX_CHUNKS      = 64;
    localparam int CHUNK_SHIFT     = $clog2(MAX_CHUNKS);

    localparam int ADDR_W   = 32;
    localparam int LEN_W    = 18;
    localparam int BSIZE_W  = 13;
    localparam int BOFF_W   = 12;
    localparam int BCOUNT_W = 32;
    localparam int TOTAL_W  = BSIZE_W + BCOUNT_W;
    localparam int LIMIT_W  = BSIZE_W + CHUNK_SHIFT;
    localparam int DIV_CNT_W = $clog2(ADDR_W) + 1;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_ABSENT = 3'd1,
        ST_RANGE  = 3'd2,
        ST_CHUNKS = 3'd3,
        ST_EMPTY  = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        KIND_RD_FULL = 2'd0,
        KIND_RD_PART = 2'd1,
        KIND_WR_FULL = 2'd2,
        KIND_WR_PART = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        REG_PRESENT = 2'd0,
        REG_BSIZE   = 2'd1,
        REG_BCOUNT  = 2'd2
    } t_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_CHECK,
        S_DIV,
        S_LIMIT,
        S_EMIT,
        S_ERR
    } t_state;

    typedef struct packed {
        logic    load;
        logic    mul;
        logic    div_init;
        logic    div_step;
        logic    out_chunk;
        logic    out_err;
        t_status err_code;
    } t_cmd;

    typedef struct packed {
        logic absent;
        logic range_err;
        logic empty;
        logic chunk_err;
        logic div_done;
        logic out_free;
        logic chunk_last;
    } t_sts;

endpackage

@@ rtl/brbs_ctrl.sv @@
`timescale 1ns / 1ps
module brbs_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  brbs_pkg::t_sts  i_sts,
    output brbs_pkg::t_cmd  o_cmd
);

    brbs_pkg::t_state  r_state, n_state;
    brbs_pkg::t_status r_err, n_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= brbs_pkg::S_IDLE;
            r_err   <= brbs_pkg::ST_OK;
        end else begin
            r_state <= n_state;
            r_err   <= n_err;
        end
    end

    always_comb begin
        n_state = r_state;
        n_err   = r_err;
        unique case (r_state)
            brbs_pkg::S_IDLE: begin
                if (i_valid) n_state = brbs_pkg::S_MUL;
            end
            brbs_pkg::S_MUL: n_state = brbs_pkg::S_CHECK;
            brbs_pkg::S_CHECK: begin
                priority if (i_sts.absent) begin
                    n_err   = brbs_pkg::ST_ABSENT;
                    n_state = brbs_pkg::S_ERR;
                end else if (i_sts.range_err) begin
                    n_err   = brbs_pkg::ST_RANGE;
                    n_state = brbs_pkg::S_ERR;
                end else if (i_sts.empty) begin
                    n_err   = brbs_pkg::ST_EMPTY;
                    n_state = brbs_pkg::S_ERR;
                end else begin
                    n_state = brbs_pkg::S_DIV;
                end
            end
            brbs_pkg::S_DIV: begin
                if (i_sts.div_done) n_state = brbs_pkg::S_LIMIT;
            end
            brbs_pkg::S_LIMIT: begin
                if (i_sts.chunk_err) begin
                    n_err   = brbs_pkg::ST_CHUNKS;
                    n_state = brbs_pkg::S_ERR;
                end else begin
                    n_state = brbs_pkg::S_EMIT;
                end
            end
            brbs_pkg::S_EMIT: begin
                if (i_sts.out_free && i_sts.chunk_last) n_state = brbs_pkg::S_IDLE;
            end
            brbs_pkg::S_ERR: begin
                if (i_sts.out_free) n_state = brbs_pkg::S_IDLE;
            end
            default: n_state = brbs_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_ready        = (r_state == brbs_pkg::S_IDLE);
        o_cmd          = '0;
        o_cmd.err_code = r_err;
        unique case (r_state)
            brbs_pkg::S_IDLE:  o_cmd.load = i_valid;
            brbs_pkg::S_MUL:   o_cmd.mul  = 1'b1;
            brbs_pkg::S_CHECK: o_cmd.div_init = 1'b1;
            brbs_pkg::S_DIV:   o_cmd.div_step = !i_sts.div_done;
            brbs_pkg::S_LIMIT: o_cmd.div_step = 1'b0;
            brbs_pkg::S_EMIT:  o_cmd.out_chunk = i_sts.out_free;
            brbs_pkg::S_ERR:   o_cmd.out_err = i_sts.out_free;
            default:           o_cmd = '0;
        endcase
    end

endmodule

@@ rtl/brbs_dp.sv @@
`timescale 1ns / 1ps
module brbs_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  brbs_pkg::t_cmd                  i_cmd,
    output brbs_pkg::t_sts                  o_sts,
    input  logic                            i_func,
    input  logic [brbs_pkg::ADDR_W-1:0]     i_byte_offset,
    input  logic [brbs_pkg::LEN_W-1:0]      i_length,
    input  logic                            i_present,
    input  logic [brbs_pkg::BSIZE_W-1:0]    i_bsize,
    input  logic [brbs_pkg::BCOUNT_W-1:0]   i_bcount,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output brbs_pkg::t_status               o_status,
    output brbs_pkg::t_kind                 o_kind,
    output logic [brbs_pkg::ADDR_W-1:0]     o_block_number,
    output logic [brbs_pkg::BOFF_W-1:0]     o_block_offset,
    output logic [brbs_pkg::BSIZE_W-1:0]    o_chunk_length,
    output logic [brbs_pkg::LEN_W-1:0]      o_buffer_offset,
    output logic                            o_last
);

    logic                             r_wr;
    logic [brbs_pkg::ADDR_W-1:0]      r_start;
    logic [brbs_pkg::LEN_W-1:0]       r_len;
    logic [brbs_pkg::TOTAL_W-1:0]     r_total;
    logic [brbs_pkg::ADDR_W-1:0]      r_quo;
    logic [brbs_pkg::BOFF_W-1:0]      r_rem;
    logic [brbs_pkg::DIV_CNT_W-1:0]   r_cnt;
    logic [brbs_pkg::LEN_W-1:0]       r_done;
    logic [brbs_pkg::LEN_W-1:0]       r_left;
    logic                             r_ovalid;

    logic [brbs_pkg::TOTAL_W-1:0]     w_prod;
    logic [brbs_pkg::ADDR_W:0]        w_end;
    logic [brbs_pkg::BSIZE_W-1:0]     w_trial;
    logic                             w_qbit;
    logic [brbs_pkg::BSIZE_W-1:0]     w_room;
    logic                             w_last;
    logic [brbs_pkg::BSIZE_W-1:0]     w_chunk;
    logic                             w_full;
    brbs_pkg::t_kind                  w_kind;

    assign w_prod  = i_bsize * i_bcount;
    assign w_end   = (brbs_pkg::ADDR_W+1)'(r_start) + (brbs_pkg::ADDR_W+1)'(r_len);
    assign w_trial = {r_rem, r_quo[brbs_pkg::ADDR_W-1]};
    assign w_qbit  = (w_trial >= i_bsize);
    assign w_room  = i_bsize - {1'b0, r_rem};
    assign w_last  = (r_left <= brbs_pkg::LEN_W'(w_room));
    assign w_chunk = w_last ? r_left[brbs_pkg::BSIZE_W-1:0] : w_room;
    assign w_full  = (r_rem == '0) && (w_chunk == i_bsize);

    always_comb begin
        unique case ({r_wr, w_full})
            2'b00:   w_kind = brbs_pkg::KIND_RD_PART;
            2'b01:   w_kind = brbs_pkg::KIND_RD_FULL;
            2'b10:   w_kind = brbs_pkg::KIND_WR_PART;
            default: w_kind = brbs_pkg::KIND_WR_FULL;
        endcase
    end

    always_comb begin
        o_sts.absent     = !i_present || (i_bsize == '0)
                           || (i_bsize > brbs_pkg::BSIZE_W'(brbs_pkg::MAX_BLOCK_BYTES));
        o_sts.range_err  = (brbs_pkg::TOTAL_W'(w_end) > r_total);
        o_sts.empty      = (r_len == '0);
        o_sts.chunk_err  = (brbs_pkg::LIMIT_W'(r_rem) + brbs_pkg::LIMIT_W'(r_len))
                           > (brbs_pkg::LIMIT_W'(i_bsize) << brbs_pkg::CHUNK_SHIFT);
        o_sts.div_done   = (r_cnt == '0);
        o_sts.out_free   = !r_ovalid || i_out_ready;
        o_sts.chunk_last = w_last;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_wr    <= i_func;
            r_start <= i_byte_offset;
            r_len   <= i_length;
        end
        if (i_cmd.mul) r_total <= w_prod;

        if (i_cmd.div_init) begin
            r_quo  <= r_start;
            r_rem  <= '0;
            r_cnt  <= brbs_pkg::DIV_CNT_W'(brbs_pkg::ADDR_W);
            r_done <= '0;
            r_left <= r_len;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[brbs_pkg::ADDR_W-2:0], w_qbit};
            r_rem <= w_qbit ? brbs_pkg::BOFF_W'(w_trial - i_bsize)
                            : w_trial[brbs_pkg::BOFF_W-1:0];
            r_cnt <= r_cnt - 1'b1;
        end else if (i_cmd.out_chunk) begin
            r_quo  <= r_quo + 1'b1;
            r_rem  <= '0;
            r_done <= r_done + brbs_pkg::LEN_W'(w_chunk);
            r_left <= r_left - brbs_pkg::LEN_W'(w_chunk);
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_chunk || i_cmd.out_err) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_chunk) begin
            o_status        <= brbs_pkg::ST_OK;
            o_kind          <= w_kind;
            o_block_number  <= r_quo;
            o_block_offset  <= r_rem;
            o_chunk_length  <= w_chunk;
            o_buffer_offset <= r_done;
            o_last          <= w_last;
        end else if (i_cmd.out_err) begin
            o_status        <= i_cmd.err_code;
            o_kind          <= brbs_pkg::KIND_RD_FULL;
            o_block_number  <= '0;
            o_block_offset  <= '0;
            o_chunk_length  <= '0;
            o_buffer_offset <= '0;
            o_last          <= 1'b1;
        end
    end

    assign o_out_valid = r_ovalid;

endmodule

@@ rtl/byte_range_block_splitter.sv @@
`timescale 1ns / 1ps
// Channel   Handshake             Payload
// request   i_valid / o_ready     i_func, i_byte_offset, i_length
// command   o_valid / i_ready     o_status, o_kind, o_block_number, o_block_offset,
//                                 o_chunk_length, o_buffer_offset, o_last
// config    psel/penable/pwrite   paddr, pwdata, prdata (pready tied high)
//
// No disk, out of range or empty: the single word follows states MUL, CHECK and ERR.
// A valid request passes MUL, CHECK, DIV and LIMIT before EMIT; in DIV the bit-serial
// divider finds the first block and offset, then EMIT sends one command per cycle
// while the output is free. Over the chunk limit, the error word follows LIMIT.
// A stalled output holds the command generator; the next request is taken while the
// final word still waits. Synchronous active-low reset; block_size resets to 512.
module byte_range_block_splitter (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_func,
    input  logic [31:0]                     i_byte_offset,
    input  logic [17:0]                     i_length,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [2:0]                      o_status,
    output logic [1:0]                      o_kind,
    output logic [31:0]                     o_block_number,
    output logic [11:0]                     o_block_offset,
    output logic [12:0]                     o_chunk_length,
    output logic [17:0]                     o_buffer_offset,
    output logic                            o_last,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [3:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    logic                                   r_present;
    logic [brbs_pkg::BSIZE_W-1:0]           r_bsize;
    logic [brbs_pkg::BCOUNT_W-1:0]          r_bcount;
    brbs_pkg::t_reg                         w_reg;
    brbs_pkg::t_cmd                         w_cmd;
    brbs_pkg::t_sts                         w_sts;
    brbs_pkg::t_status                      w_status;
    brbs_pkg::t_kind                        w_kind;

    assign w_reg  = brbs_pkg::t_reg'(paddr[3:2]);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= 1'b0;
            r_bsize   <= brbs_pkg::BSIZE_W'(512);
            r_bcount  <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (w_reg)
                brbs_pkg::REG_PRESENT: r_present <= pwdata[0];
                brbs_pkg::REG_BSIZE:   r_bsize   <= pwdata[brbs_pkg::BSIZE_W-1:0];
                brbs_pkg::REG_BCOUNT:  r_bcount  <= pwdata;
                default:               r_present <= r_present;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg)
            brbs_pkg::REG_PRESENT: prdata = {31'b0, r_present};
            brbs_pkg::REG_BSIZE:   prdata = 32'(r_bsize);
            brbs_pkg::REG_BCOUNT:  prdata = r_bcount;
            default:               prdata = '0;
        endcase
    end

    brbs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    brbs_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_func          (i_func),
        .i_byte_offset   (i_byte_offset),
        .i_length        (i_length),
        .i_present       (r_present),
        .i_bsize         (r_bsize),
        .i_bcount        (r_bcount),
        .i_out_ready     (i_ready),
        .o_out_valid     (o_valid),
        .o_status        (w_status),
        .o_kind          (w_kind),
        .o_block_number  (o_block_number),
        .o_block_offset  (o_block_offset),
        .o_chunk_length  (o_chunk_length),
        .o_buffer_offset (o_buffer_offset),
        .o_last          (o_last)
    );

    assign o_status = w_status;
    assign o_kind   = w_kind;

endmodule

@@ rtl/brbs_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module brbs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [2:0]  o_status,
    input logic [11:0] o_block_offset,
    input logic [12:0] o_chunk_length,
    input logic [17:0] o_buffer_offset,
    input logic        o_last
);

    `BRBS_ASSERT_ALWAYS(a_no_word_after_reset, i_clk, !i_rst_n |=> !o_valid)
    `BRBS_ASSERT(a_word_held, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid)
    `BRBS_ASSERT(a_error_is_last, i_clk, i_rst_n, o_valid && (o_status != brbs_pkg::ST_OK) |-> o_last && (o_chunk_length == '0))
    `BRBS_ASSERT(a_error_zeroed, i_clk, i_rst_n, o_valid && (o_status != brbs_pkg::ST_OK) |-> (o_block_offset == '0) && (o_buffer_offset == '0))
    `BRBS_ASSERT(a_chunk_nonempty, i_clk, i_rst_n, o_valid && (o_status == brbs_pkg::ST_OK) |-> (o_chunk_length != '0))

endmodule

bind byte_range_block_splitter brbs_checker u_brbs_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_status        (o_status),
    .o_block_offset  (o_block_offset),
    .o_chunk_length  (o_chunk_length),
    .o_buffer_offset (o_buffer_offset),
    .o_last          (o_last)
);

@@ tb/byte_range_block_splitter_checker.sv @@
`timescale 1ns / 1ps
module byte_range_block_splitter_checker
    import brbs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic        i_func,
    input  logic [31:0] i_byte_offset,
    input  logic [17:0] i_length,
    input  logic        i_cmd_valid,
    input  logic        i_cmd_ready,
    input  logic [2:0]  i_status,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_block_number,
    input  logic [11:0] i_block_offset,
    input  logic [12:0] i_chunk_length,
    input  logic [17:0] i_buffer_offset,
    input  logic        i_last,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [3:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    output int          o_errors,
    output int          o_pending,
    output int          o_words
);

    typedef struct packed {
        t_status     status;
        t_kind       kind;
        logic [31:0] block_number;
        logic [11:0] block_offset;
        logic [12:0] chunk_length;
        logic [17:0] buffer_offset;
        logic        last;
    } t_split_word;

    t_split_word expected_words[$];
    logic        cfg_present;
    logic [12:0] cfg_bsize;
    logic [31:0] cfg_bcount;
    int          err_cnt;
    int          word_cnt;

    initial begin
        o_errors  = 0;
        o_pending = 0;
        o_words   = 0;
        err_cnt   = 0;
        word_cnt  = 0;
    end

    function automatic void push_status_word(t_status st);
        t_split_word w;
        w = '0;
        w.status = st;
        w.kind   = KIND_RD_FULL;
        w.last   = 1'b1;
        expected_words.push_back(w);
    endfunction

    function automatic void split_into_commands(logic wr, logic [31:0] start,
                                                logic [17:0] len);
        logic [63:0] bs;
        logic [63:0] total;
        logic [63:0] end_addr;
        logic [63:0] n_blocks;
        logic [63:0] done;
        logic [63:0] cur;
        logic [63:0] boff;
        logic [63:0] chunk;
        t_split_word w;
        bs = 64'(cfg_bsize);
        if (!cfg_present || bs == 0 || bs > MAX_BLOCK_BYTES) begin
            push_status_word(ST_ABSENT);
            return;
        end
        total    = bs * 64'(cfg_bcount);
        end_addr = 64'(start) + 64'(len);
        if (end_addr > total) begin
            push_status_word(ST_RANGE);
            return;
        end
        if (len == 0) begin
            push_status_word(ST_EMPTY);
            return;
        end
        n_blocks = (end_addr - 1) / bs - 64'(start) / bs + 1;
        if (n_blocks > MAX_CHUNKS) begin
            push_status_word(ST_CHUNKS);
            return;
        end
        done = 0;
        while (done < 64'(len)) begin
            cur   = 64'(start) + done;
            boff  = cur % bs;
            chunk = 64'(len) - done;
            if (chunk > bs - boff) chunk = bs - boff;
            w.status = ST_OK;
            if (boff == 0 && chunk == bs) w.kind = wr ? KIND_WR_FULL : KIND_RD_FULL;
            else w.kind = wr ? KIND_WR_PART : KIND_RD_PART;
            w.block_number  = 32'(cur / bs);
            w.block_offset  = boff[11:0];
            w.chunk_length  = chunk[12:0];
            w.buffer_offset = done[17:0];
            done = done + chunk;
            w.last = (done >= 64'(len));
            expected_words.push_back(w);
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        err_cnt++;
        if (err_cnt <= 40)
            $display("%0t: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    always @(posedge i_clk) begin
        t_split_word w;
        if (!i_rst_n) begin
            cfg_present = 1'b0;
            cfg_bsize   = 13'd512;
            cfg_bcount  = 32'd0;
            expected_words.delete();
        end else begin
            if (i_cmd_valid && i_cmd_ready) begin
                word_cnt++;
                if (expected_words.size() == 0) begin
                    report_mismatch("unexpected word, status", 32'(i_status), 32'(ST_OK));
                end else begin
                    w = expected_words.pop_front();
                    if (i_status !== w.status)
                        report_mismatch("status", 32'(i_status), 32'(w.status));
                    if (i_kind !== w.kind)
                        report_mismatch("kind", 32'(i_kind), 32'(w.kind));
                    if (i_block_number !== w.block_number)
                        report_mismatch("block_number", i_block_number, w.block_number);
                    if (i_block_offset !== w.block_offset)
                        report_mismatch("block_offset", 32'(i_block_offset),
                                        32'(w.block_offset));
                    if (i_chunk_length !== w.chunk_length)
                        report_mismatch("chunk_length", 32'(i_chunk_length),
                                        32'(w.chunk_length));
                    if (i_buffer_offset !== w.buffer_offset)
                        report_mismatch("buffer_offset", 32'(i_buffer_offset),
                                        32'(w.buffer_offset));
                    if (i_last !== w.last)
                        report_mismatch("last", 32'(i_last), 32'(w.last));
                end
            end
            if (i_req_valid && i_req_ready)
                split_into_commands(i_func, i_byte_offset, i_length);
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr[1:0] == 2'b00) begin
                case (t_reg'(i_paddr[3:2]))
                    REG_PRESENT: cfg_present = i_pwdata[0];
                    REG_BSIZE:   cfg_bsize   = i_pwdata[12:0];
                    REG_BCOUNT:  cfg_bcount  = i_pwdata;
                    default: ;
                endcase
            end
        end
        o_errors  <= err_cnt;
        o_pending <= expected_words.size();
        o_words   <= word_cnt;
    end

endmodule

@@ tb/byte_range_block_splitter_tb.sv @@
`timescale 1ns / 1ps
module byte_range_block_splitter_tb;
    import brbs_pkg::*;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_func = 1'b0;
    logic [31:0] i_byte_offset = '0;
    logic [17:0] i_length = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [2:0]  o_status;
    logic [1:0]  o_kind;
    logic [31:0] o_block_number;
    logic [11:0] o_block_offset;
    logic [12:0] o_chunk_length;
    logic [17:0] o_buffer_offset;
    logic        o_last;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int          fail_count;
    int          pending_words;
    int          words_checked;
    int          req_count = 0;
    int          setting_count = 0;
    int          stall_left = 0;
    logic        quiet = 1'b0;
    logic        cur_present;
    logic [12:0] cur_bsize;
    logic [31:0] cur_bcount;

    byte_range_block_splitter u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_func          (i_func),
        .i_byte_offset   (i_byte_offset),
        .i_length        (i_length),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_status        (o_status),
        .o_kind          (o_kind),
        .o_block_number  (o_block_number),
        .o_block_offset  (o_block_offset),
        .o_chunk_length  (o_chunk_length),
        .o_buffer_offset (o_buffer_offset),
        .o_last          (o_last),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    byte_range_block_splitter_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_valid     (i_valid),
        .i_req_ready     (o_ready),
        .i_func          (i_func),
        .i_byte_offset   (i_byte_offset),
        .i_length        (i_length),
        .i_cmd_valid     (o_valid),
        .i_cmd_ready     (i_ready),
        .i_status        (o_status),
        .i_kind          (o_kind),
        .i_block_number  (o_block_number),
        .i_block_offset  (o_block_offset),
        .i_chunk_length  (o_chunk_length),
        .i_buffer_offset (o_buffer_offset),
        .i_last          (o_last),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .i_pready        (pready),
        .o_errors        (fail_count),
        .o_pending       (pending_words),
        .o_words         (words_checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #30_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // random output backpressure in bursts, none started in the quiet phase
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            i_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!quiet && $urandom_range(0, 11) == 0) begin
            i_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 8);
        end else begin
            i_ready <= 1'b1;
        end
    end

    task automatic send_request(input logic wr, input logic [31:0] off,
                                input logic [17:0] len);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_func        <= wr;
        i_byte_offset <= off;
        i_length      <= len;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        req_count++;
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_words != 0) @(posedge i_clk);
        repeat (45) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
    endtask

    task automatic apply_setting(input logic present, input logic [12:0] bsize,
                                 input logic [31:0] bcount);
        settle();
        write_reg(REG_PRESENT, 32'(present));
        write_reg(REG_BSIZE, 32'(bsize));
        write_reg(REG_BCOUNT, bcount);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_present = present;
        cur_bsize   = bsize;
        cur_bcount  = bcount;
        setting_count++;
    endtask

    // mostly in-range, chunk-limited requests; some noise
    task automatic send_random();
        logic [63:0] bs_eff;
        logic [63:0] span;
        logic [63:0] total;
        logic [63:0] room;
        logic [63:0] tmp;
        logic [31:0] off;
        logic [17:0] len;
        int          pick;
        bs_eff = (cur_bsize == 0 || cur_bsize > MAX_BLOCK_BYTES) ? 64'd512 : 64'(cur_bsize);
        span = bs_eff * MAX_CHUNKS;
        if (span > 64'd262143) span = 64'd262143;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            len = '0;
        end else if (pick == 1) begin
            len = 18'($urandom);
        end else if (pick <= 4) begin
            tmp = bs_eff * $urandom_range(1, MAX_CHUNKS);
            if (tmp > 64'd262143) tmp = 64'd262143;
            len = tmp[17:0];
        end else begin
            len = 18'($urandom_range(1, 32'(span)));
        end
        total = bs_eff * 64'(cur_bcount);
        if ($urandom_range(0, 7) == 0 || total < 64'(len)) begin
            off = $urandom;
        end else begin
            room = total - 64'(len);
            off = (room > 64'hFFFF_FFFF) ? $urandom : $urandom_range(0, 32'(room));
        end
        if ($urandom_range(0, 2) == 0) off = off - 32'(64'(off) % bs_eff);
        send_request(1'($urandom), off, len);
    endtask

    initial begin
        cur_present = 1'b0;
        cur_bsize   = 13'd512;
        cur_bcount  = 32'd0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: no disk
        send_request(1'b1, 32'hFFFF_FFFF, 18'h3FFFF);

        apply_setting(1'b1, 13'd512, 32'd1024);
        send_request(1'b0, 32'd0, 18'd0);
        send_request(1'b0, 32'd0, 18'd512);
        send_request(1'b1, 32'd512, 18'd1024);
        send_request(1'b0, 32'd100, 18'd50);
        send_request(1'b1, 32'd1000, 18'd2000);
        send_request(1'b1, 32'd0, 18'd32768);
        send_request(1'b0, 32'd1, 18'd32768);
        send_request(1'b0, 32'd523776, 18'd512);
        send_request(1'b0, 32'd523777, 18'd512);
        send_request(1'b0, 32'd524288, 18'd0);
        send_request(1'b1, 32'd524289, 18'd0);

        // unusable block sizes
        apply_setting(1'b1, 13'd0, 32'd1024);
        send_request(1'b0, 32'd0, 18'd16);
        apply_setting(1'b1, 13'd4097, 32'd1024);
        send_request(1'b1, 32'd0, 18'd16);
        apply_setting(1'b1, 13'h1FFF, 32'hFFFF_FFFF);
        send_request(1'b0, 32'd0, 18'd0);

        apply_setting(1'b1, 13'd4096, 32'hFFFF_FFFF);
        send_request(1'b0, 32'hFFFF_FFFF, 18'h3FFFF);
        send_request(1'b1, 32'hFFFF_F001, 18'h3FFFF);
        send_request(1'b0, 32'd0, 18'h3FFFF);
        send_request(1'b1, 32'hFFFF_FFFF, 18'd1);

        apply_setting(1'b1, 13'd1, 32'd100);
        send_request(1'b0, 32'd5, 18'd64);
        send_request(1'b0, 32'd0, 18'd65);
        send_request(1'b1, 32'd99, 18'd1);
        send_request(1'b0, 32'd100, 18'd1);

        apply_setting(1'b1, 13'd1, 32'd0);
        send_request(1'b0, 32'd0, 18'd0);
        send_request(1'b1, 32'd0, 18'd1);

        for (int ph = 0; ph < 8; ph++) begin
            logic        p;
            logic [12:0] bs;
            logic [31:0] cnt;
            p = ($urandom_range(0, 9) != 0);
            case ($urandom_range(0, 5))
                0:       bs = 13'd1;
                1:       bs = 13'd512;
                2:       bs = 13'd4096;
                3:       bs = 13'($urandom_range(1, 4096));
                4:       bs = 13'($urandom_range(0, 8191));
                default: bs = 13'($urandom_range(2, 64));
            endcase
            case ($urandom_range(0, 3))
                0:       cnt = 32'hFFFF_FFFF;
                1:       cnt = $urandom_range(1, 4096);
                2:       cnt = $urandom;
                default: cnt = $urandom_range(0, 3);
            endcase
            if (ph == 7) begin
                p   = 1'b1;
                bs  = 13'($urandom_range(1, 4096));
                cnt = 32'hFFFF_FFFF;
            end
            apply_setting(p, bs, cnt);
            if (ph == 7) quiet = 1'b1;
            repeat (37) send_random();
        end

        settle();
        $display("Ran %0d requests over %0d register settings, %0d command words checked.",
                 req_count, setting_count, words_checked);
        $display("Covered all statuses, all four command kinds and the field extremes.");
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ byte_range_block_splitter.f @@
+incdir+rtl
rtl/brbs_pkg.sv
rtl/brbs_ctrl.sv
rtl/brbs_dp.sv
rtl/byte_range_block_splitter.sv
rtl/brbs_checker.sv
tb/byte_range_block_splitter_checker.sv
tb/byte_range_block_splitter_tb.sv
